### rtl/psched_pkg.sv
// Package for the priority task scheduler: sizes, operation and state codes,
// and the request type of the shared arithmetic unit. No dependencies.
`timescale 1ns / 1ps
package psched_pkg;

   localparam int TASKS  = 32;
   localparam int LEVELS = 32;
   localparam int TASK_W  = $clog2(TASKS);
   localparam int LEVEL_W = $clog2(LEVELS);
   localparam int CNT_W   = $clog2(TASKS + 1);

   localparam logic [2:0] FUNC_ACTIVATE = 3'd0;
   localparam logic [2:0] FUNC_SLEEP    = 3'd1;
   localparam logic [2:0] FUNC_TSLEEP   = 3'd2;
   localparam logic [2:0] FUNC_WAKEUP   = 3'd3;
   localparam logic [2:0] FUNC_DORMANT  = 3'd4;
   localparam logic [2:0] FUNC_TICK     = 3'd5;

   localparam logic [1:0] ST_STANDBY = 2'd0;
   localparam logic [1:0] ST_READY   = 2'd1;
   localparam logic [1:0] ST_WAIT    = 2'd2;
   localparam logic [1:0] ST_DORMANT = 2'd3;

   typedef enum logic {
      ALU_ADD_SAT,
      ALU_LE
   } alu_op_type;

   typedef struct packed {
      alu_op_type  op;
      logic [31:0] a;
      logic [31:0] b;
   } alu_req_type;

   typedef struct packed {
      logic [31:0] sum;
      logic        le;
   } alu_rsp_type;

endpackage

### rtl/psched_alu.sv
// Shared 32-bit unit of the scheduler: saturating add and unsigned compare.
// Depends on psched_pkg.
`timescale 1ns / 1ps
module psched_alu (
   input  psched_pkg::alu_req_type req,
   output psched_pkg::alu_rsp_type rsp
);

   logic [32:0] sum_wide;

   // add with saturation at all ones, compare a <= b
   always_comb begin
      sum_wide = {1'b0, req.a} + {1'b0, req.b};
      rsp.sum  = sum_wide[32] ? 32'hffff_ffff : sum_wide[31:0];
      rsp.le   = (req.op == psched_pkg::ALU_LE) && (req.a <= req.b);
   end

endmodule

### rtl/psched_ffs.sv
// Find-first-set over the bitmap of non-empty priority levels.
// Depends on psched_pkg.
`timescale 1ns / 1ps
module psched_ffs (
   input  logic [psched_pkg::LEVELS-1:0]  bits,
   output logic [psched_pkg::LEVEL_W-1:0] first,
   output logic                           any
);

   // scan from the least urgent level down so the most urgent wins
   always_comb begin
      first = '0;
      for (int i = psched_pkg::LEVELS - 1; i >= 0; i--) begin
         if (bits[i]) begin
            first = psched_pkg::LEVEL_W'(i);
         end
      end
      any = |bits;
   end

endmodule

### rtl/priority_task_scheduler_with_timeouts.sv
// After decode, activate adds a push; sleep and dormant a pull; wakeup an unlink from the
// timeout list if on it, then a push; timed sleep a pull, the wake-time add and, in a
// non-empty list, a walk and link; tick a counter step and the wake of each due list head.
// The final state waits for a free result slot. One word is in work at a time; the next is
// taken once the previous result is registered; walks, adds and compares share one unit.
// Synchronous active-high reset clears task states, bitmap, tick counter and timeout list.
`timescale 1ns / 1ps
module priority_task_scheduler_with_timeouts (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [2:0]  req_func,
   input  logic [4:0]  req_task_id,
   input  logic [4:0]  req_priority_req,
   input  logic [31:0] req_duration,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_status,
   output logic [4:0]  rsp_next_task,
   output logic        rsp_next_valid,
   output logic        rsp_dispatch,
   output logic [5:0]  rsp_woken_count
);

   localparam int TW = psched_pkg::TASK_W;
   localparam int LW = psched_pkg::LEVEL_W;
   localparam int CW = psched_pkg::CNT_W;
   localparam int NT = psched_pkg::TASKS;
   localparam int NL = psched_pkg::LEVELS;

   typedef enum logic [3:0] {
      S_IDLE, S_DECODE, S_PULL, S_WADD, S_INS_START, S_INS_WALK, S_INS_LINK,
      S_TREM, S_PUSH, S_TICK_ADD, S_TICK_CHK, S_FINAL
   } state_type;

   state_type state_ff, state_in;

   logic [2:0]  func_ff, func_in;
   logic [4:0]  tid_ff, tid_in;
   logic [4:0]  prio_ff, prio_in;
   logic [31:0] dur_ff, dur_in;
   logic        status_ff, status_in;
   logic        dispatch_ff, dispatch_in;
   logic [5:0]  woken_ff, woken_in;
   logic [TW-1:0] cur_ff, cur_in;
   logic [TW-1:0] ptr_ff, ptr_in;
   logic [CW-1:0] idx_ff, idx_in;
   logic        front_ff, front_in;

   logic [31:0]   tick_ff, tick_in;
   logic [NL-1:0] bits_ff, bits_in;
   logic [1:0]    run_ff [NT];
   logic [1:0]    run_in [NT];
   logic [LW-1:0] level_ff [NT];
   logic [LW-1:0] level_in [NT];
   logic [TW-1:0] lhead_ff [NL];
   logic [TW-1:0] lhead_in [NL];
   logic [TW-1:0] ltail_ff [NL];
   logic [TW-1:0] ltail_in [NL];
   logic [TW-1:0] rsucc_ff [NT];
   logic [TW-1:0] rsucc_in [NT];
   logic [TW-1:0] rpred_ff [NT];
   logic [TW-1:0] rpred_in [NT];
   logic [31:0]   wake_ff [NT];
   logic [31:0]   wake_in [NT];
   logic [TW-1:0] tsucc_ff [NT];
   logic [TW-1:0] tsucc_in [NT];
   logic [TW-1:0] tpred_ff [NT];
   logic [TW-1:0] tpred_in [NT];
   logic [TW-1:0] thead_ff, thead_in;
   logic [CW-1:0] tcount_ff, tcount_in;
   logic [NT-1:0] onlist_ff, onlist_in;

   logic        rsp_valid_ff, rsp_valid_in;
   logic        rsp_status_ff, rsp_status_in;
   logic [4:0]  rsp_next_ff, rsp_next_in;
   logic        rsp_nvalid_ff, rsp_nvalid_in;
   logic        rsp_disp_ff, rsp_disp_in;
   logic [5:0]  rsp_woken_ff, rsp_woken_in;

   psched_pkg::alu_req_type alu_req;
   psched_pkg::alu_rsp_type alu_rsp;
   logic [LW-1:0] ffs_first;
   logic          ffs_any;
   logic          slot_free;

   psched_alu u_alu (.req(alu_req), .rsp(alu_rsp));
   psched_ffs u_ffs (.bits(bits_ff), .first(ffs_first), .any(ffs_any));

   assign req_ready       = (state_ff == S_IDLE);
   assign slot_free       = !rsp_valid_ff || rsp_ready;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_next_task   = rsp_next_ff;
   assign rsp_next_valid  = rsp_nvalid_ff;
   assign rsp_dispatch    = rsp_disp_ff;
   assign rsp_woken_count = rsp_woken_ff;

   // steer the shared unit for the current step
   always_comb begin
      alu_req.op = psched_pkg::ALU_LE;
      alu_req.a  = wake_ff[cur_ff];
      alu_req.b  = wake_ff[ptr_ff];
      unique case (state_ff)
         S_WADD: begin
            alu_req.op = psched_pkg::ALU_ADD_SAT;
            alu_req.a  = tick_ff;
            alu_req.b  = dur_ff;
         end
         S_TICK_ADD: begin
            alu_req.op = psched_pkg::ALU_ADD_SAT;
            alu_req.a  = tick_ff;
            alu_req.b  = 32'h0000_0001;
         end
         S_TICK_CHK: begin
            alu_req.a = wake_ff[thead_ff];
            alu_req.b = tick_ff;
         end
         default: begin
         end
      endcase
   end

   // sequencer next state and list updates
   always_comb begin
      logic [LW-1:0] lv;
      logic [NL-1:0] bit_mask;
      logic [TW-1:0] pr;
      logic [TW-1:0] sc;

      state_in = state_ff;
      func_in = func_ff; tid_in = tid_ff; prio_in = prio_ff; dur_in = dur_ff;
      status_in = status_ff; dispatch_in = dispatch_ff; woken_in = woken_ff;
      cur_in = cur_ff; ptr_in = ptr_ff; idx_in = idx_ff; front_in = front_ff;
      tick_in = tick_ff; bits_in = bits_ff;
      run_in = run_ff; level_in = level_ff; lhead_in = lhead_ff; ltail_in = ltail_ff;
      rsucc_in = rsucc_ff; rpred_in = rpred_ff; wake_in = wake_ff;
      tsucc_in = tsucc_ff; tpred_in = tpred_ff;
      thead_in = thead_ff; tcount_in = tcount_ff; onlist_in = onlist_ff;
      rsp_status_in = rsp_status_ff; rsp_next_in = rsp_next_ff;
      rsp_nvalid_in = rsp_nvalid_ff; rsp_disp_in = rsp_disp_ff;
      rsp_woken_in = rsp_woken_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;

      lv       = level_ff[cur_ff];
      bit_mask = {{(NL-1){1'b0}}, 1'b1} << lv;
      pr       = tpred_ff[cur_ff];
      sc       = tsucc_ff[cur_ff];

      unique case (state_ff)
         // take a word
         S_IDLE: begin
            if (req_valid) begin
               func_in = req_func; tid_in = req_task_id;
               prio_in = req_priority_req; dur_in = req_duration;
               status_in = 1'b0; dispatch_in = 1'b0; woken_in = '0;
               state_in = S_DECODE;
            end
         end
         // check the task state and pick the path
         S_DECODE: begin
            cur_in   = tid_ff[TW-1:0];
            state_in = S_FINAL;
            if (func_ff <= psched_pkg::FUNC_DORMANT && 32'(tid_ff) >= NT) begin
               status_in = 1'b1;
            end else begin
               case (func_ff)
                  psched_pkg::FUNC_ACTIVATE: begin
                     if (32'(prio_ff) >= NL) begin
                        status_in = 1'b1;
                     end else if (run_ff[tid_ff[TW-1:0]] == psched_pkg::ST_STANDBY) begin
                        level_in[tid_ff[TW-1:0]] = prio_ff[LW-1:0];
                        dispatch_in = 1'b1;
                        state_in = S_PUSH;
                     end
                  end
                  psched_pkg::FUNC_SLEEP, psched_pkg::FUNC_TSLEEP,
                  psched_pkg::FUNC_DORMANT: begin
                     if (run_ff[tid_ff[TW-1:0]] != psched_pkg::ST_READY) begin
                        status_in = 1'b1;
                     end else begin
                        dispatch_in = 1'b1;
                        state_in = S_PULL;
                     end
                  end
                  psched_pkg::FUNC_WAKEUP: begin
                     if (run_ff[tid_ff[TW-1:0]] != psched_pkg::ST_WAIT) begin
                        status_in = 1'b1;
                     end else begin
                        dispatch_in = 1'b1;
                        state_in = onlist_ff[tid_ff[TW-1:0]] ? S_TREM : S_PUSH;
                     end
                  end
                  psched_pkg::FUNC_TICK: begin
                     state_in = S_TICK_ADD;
                  end
                  default: begin
                  end
               endcase
            end
         end
         // drop the task from its ready queue
         S_PULL: begin
            if (lhead_ff[lv] == cur_ff && ltail_ff[lv] == cur_ff) begin
               bits_in = bits_ff & ~bit_mask;
            end else if (lhead_ff[lv] == cur_ff) begin
               lhead_in[lv] = rsucc_ff[cur_ff];
            end else if (ltail_ff[lv] == cur_ff) begin
               ltail_in[lv] = rpred_ff[cur_ff];
            end else begin
               rsucc_in[rpred_ff[cur_ff]] = rsucc_ff[cur_ff];
               rpred_in[rsucc_ff[cur_ff]] = rpred_ff[cur_ff];
            end
            if (func_ff == psched_pkg::FUNC_DORMANT) begin
               run_in[cur_ff] = psched_pkg::ST_DORMANT;
               state_in = S_FINAL;
            end else begin
               run_in[cur_ff] = psched_pkg::ST_WAIT;
               state_in = (func_ff == psched_pkg::FUNC_TSLEEP) ? S_WADD : S_FINAL;
            end
         end
         // wake time with saturation
         S_WADD: begin
            wake_in[cur_ff] = alu_rsp.sum;
            state_in = S_INS_START;
         end
         S_INS_START: begin
            if (tcount_ff == '0) begin
               thead_in = cur_ff;
               tsucc_in[cur_ff] = cur_ff;
               tpred_in[cur_ff] = cur_ff;
               tcount_in = tcount_ff + CW'(1);
               onlist_in[cur_ff] = 1'b1;
               state_in = S_FINAL;
            end else begin
               ptr_in = thead_ff; idx_in = '0; front_in = 1'b1;
               state_in = S_INS_WALK;
            end
         end
         // advance along the timeout list to the first later-or-equal entry
         S_INS_WALK: begin
            if (idx_ff == tcount_ff || alu_rsp.le) begin
               state_in = S_INS_LINK;
            end else begin
               ptr_in = tsucc_ff[ptr_ff];
               idx_in = idx_ff + CW'(1);
               front_in = 1'b0;
            end
         end
         // link in before the walk pointer
         S_INS_LINK: begin
            tsucc_in[tpred_ff[ptr_ff]] = cur_ff;
            tpred_in[cur_ff] = tpred_ff[ptr_ff];
            tsucc_in[cur_ff] = ptr_ff;
            tpred_in[ptr_ff] = cur_ff;
            if (front_ff) thead_in = cur_ff;
            tcount_in = tcount_ff + CW'(1);
            onlist_in[cur_ff] = 1'b1;
            state_in = S_FINAL;
         end
         // unlink from the timeout list
         S_TREM: begin
            if (tcount_ff <= CW'(1)) begin
               tcount_in = '0;
            end else begin
               tsucc_in[pr] = sc;
               tpred_in[sc] = pr;
               if (thead_ff == cur_ff) thead_in = sc;
               tcount_in = tcount_ff - CW'(1);
            end
            onlist_in[cur_ff] = 1'b0;
            state_in = S_PUSH;
         end
         // append to the tail of the task's level
         S_PUSH: begin
            run_in[cur_ff] = psched_pkg::ST_READY;
            if ((bits_ff & bit_mask) == '0) begin
               lhead_in[lv] = cur_ff;
            end else begin
               rsucc_in[ltail_ff[lv]] = cur_ff;
               rpred_in[cur_ff] = ltail_ff[lv];
            end
            ltail_in[lv] = cur_ff;
            bits_in = bits_ff | bit_mask;
            state_in = (func_ff == psched_pkg::FUNC_TICK) ? S_TICK_CHK : S_FINAL;
         end
         S_TICK_ADD: begin
            tick_in = alu_rsp.sum;
            state_in = S_TICK_CHK;
         end
         // wake the list head while its time has come
         S_TICK_CHK: begin
            if (tcount_ff != '0 && alu_rsp.le) begin
               cur_in = thead_ff;
               woken_in = woken_ff + 6'd1;
               dispatch_in = 1'b1;
               state_in = S_TREM;
            end else begin
               state_in = S_FINAL;
            end
         end
         // register the result word once the output slot is free
         S_FINAL: begin
            if (slot_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = status_ff;
               rsp_next_in   = ffs_any ? 5'(lhead_ff[ffs_first]) : 5'd0;
               rsp_nvalid_in = ffs_any;
               rsp_disp_in   = dispatch_ff;
               rsp_woken_in  = woken_ff;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // hold state and registered outputs
   always_ff @(posedge clock) begin
      func_ff <= func_in; tid_ff <= tid_in; prio_ff <= prio_in; dur_ff <= dur_in;
      status_ff <= status_in; dispatch_ff <= dispatch_in; woken_ff <= woken_in;
      cur_ff <= cur_in; ptr_ff <= ptr_in; idx_ff <= idx_in; front_ff <= front_in;
      level_ff <= level_in; lhead_ff <= lhead_in; ltail_ff <= ltail_in;
      rsucc_ff <= rsucc_in; rpred_ff <= rpred_in; wake_ff <= wake_in;
      tsucc_ff <= tsucc_in; tpred_ff <= tpred_in;
      rsp_status_ff <= rsp_status_in; rsp_next_ff <= rsp_next_in;
      rsp_nvalid_ff <= rsp_nvalid_in; rsp_disp_ff <= rsp_disp_in;
      rsp_woken_ff <= rsp_woken_in;
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         tick_ff      <= '0;
         bits_ff      <= '0;
         thead_ff     <= '0;
         tcount_ff    <= '0;
         onlist_ff    <= '0;
         for (int i = 0; i < NT; i++) run_ff[i] <= psched_pkg::ST_STANDBY;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         tick_ff      <= tick_in;
         bits_ff      <= bits_in;
         thead_ff     <= thead_in;
         tcount_ff    <= tcount_in;
         onlist_ff    <= onlist_in;
         run_ff       <= run_in;
      end
   end

`ifndef SYNTHESIS
   a_count_matches: assert property (@(posedge clock) disable iff (reset)
      32'($countones(onlist_ff)) == 32'(tcount_ff))
      else $error("timeout list count disagrees with membership bits");
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      32'(tcount_ff) <= NT)
      else $error("timeout list count beyond task count");
   a_final_loads: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_FINAL) && slot_free |=> rsp_valid_ff && (state_ff == S_IDLE))
      else $error("result word not loaded on completion");
`endif

endmodule

### bench/tb_priority_task_scheduler_with_timeouts.sv
// Self-checking bench for the priority task scheduler with timeouts.
// Holds its own scheduler model and checks every result word; needs psched_pkg and the DUT.
`timescale 1ns / 1ps
module tb_priority_task_scheduler_with_timeouts;

   typedef struct packed {
      logic       status;
      logic [4:0] next_task;
      logic       next_valid;
      logic       dispatch;
      logic [5:0] woken_count;
   } sched_result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [2:0]  req_func = psched_pkg::FUNC_TICK;
   logic [4:0]  req_task_id = '0;
   logic [4:0]  req_priority_req = '0;
   logic [31:0] req_duration = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic        rsp_status;
   logic [4:0]  rsp_next_task;
   logic        rsp_next_valid;
   logic        rsp_dispatch;
   logic [5:0]  rsp_woken_count;

   priority_task_scheduler_with_timeouts i_dut (.*);

   // scheduler model state
   logic [31:0] m_ticks;
   logic [31:0] m_ready_bits;
   logic [1:0]  m_state [psched_pkg::TASKS];
   logic [4:0]  m_level [psched_pkg::TASKS];
   logic [4:0]  m_head [psched_pkg::LEVELS];
   logic [4:0]  m_tail [psched_pkg::LEVELS];
   logic [4:0]  m_rsucc [psched_pkg::TASKS];
   logic [4:0]  m_rpred [psched_pkg::TASKS];
   logic [31:0] m_wake [psched_pkg::TASKS];
   logic [4:0]  m_tsucc [psched_pkg::TASKS];
   logic [4:0]  m_tpred [psched_pkg::TASKS];
   logic [4:0]  m_thead;
   int          m_tcount;
   logic        m_on_timer [psched_pkg::TASKS];

   sched_result_type expected_words [$];
   int          errors = 0;
   longint      cycle = 0;
   bit          calm = 1'b0;     // no idling on either side
   bit          rx_hold = 1'b0;  // long receiver hold-off request
   int          long_hold = 0;

   // free-running clock
   initial begin
      forever #5 clock = ~clock;
   end

   function automatic void model_reset();
      m_ticks = '0; m_ready_bits = '0; m_thead = '0; m_tcount = 0;
      for (int i = 0; i < psched_pkg::TASKS; i++) begin
         m_state[i] = psched_pkg::ST_STANDBY; m_on_timer[i] = 1'b0;
         m_level[i] = '0; m_rsucc[i] = '0; m_rpred[i] = '0;
         m_wake[i] = '0; m_tsucc[i] = '0; m_tpred[i] = '0;
      end
      for (int i = 0; i < psched_pkg::LEVELS; i++) begin
         m_head[i] = '0; m_tail[i] = '0;
      end
   endfunction

   function automatic void queue_append(logic [4:0] t);
      logic [4:0] lv;
      lv = m_level[t];
      if (!m_ready_bits[lv]) m_head[lv] = t;
      else begin
         m_rsucc[m_tail[lv]] = t;
         m_rpred[t] = m_tail[lv];
      end
      m_tail[lv] = t;
      m_ready_bits[lv] = 1'b1;
   endfunction

   function automatic void queue_unlink(logic [4:0] t);
      logic [4:0] lv;
      bit hd, tl;
      lv = m_level[t];
      hd = (m_head[lv] == t);
      tl = (m_tail[lv] == t);
      if (hd && tl) m_ready_bits[lv] = 1'b0;
      else if (hd) m_head[lv] = m_rsucc[t];
      else if (tl) m_tail[lv] = m_rpred[t];
      else begin
         m_rsucc[m_rpred[t]] = m_rsucc[t];
         m_rpred[m_rsucc[t]] = m_rpred[t];
      end
   endfunction

   function automatic void timeout_insert(logic [4:0] t);
      logic [4:0] p, pr;
      bit front;
      if (m_tcount == 0) begin
         m_thead = t; m_tsucc[t] = t; m_tpred[t] = t;
      end else begin
         p = m_thead;
         front = 1'b1;
         for (int i = 0; i < m_tcount; i++) begin
            if (m_wake[t] <= m_wake[p]) break;
            p = m_tsucc[p];
            front = 1'b0;
         end
         pr = m_tpred[p];
         m_tsucc[pr] = t; m_tpred[t] = pr;
         m_tsucc[t] = p; m_tpred[p] = t;
         if (front) m_thead = t;
      end
      m_tcount++;
      m_on_timer[t] = 1'b1;
   endfunction

   function automatic void release_task(logic [4:0] t);
      if (m_on_timer[t]) begin
         if (m_tcount <= 1) m_tcount = 0;
         else begin
            m_tsucc[m_tpred[t]] = m_tsucc[t];
            m_tpred[m_tsucc[t]] = m_tpred[t];
            if (m_thead == t) m_thead = m_tsucc[t];
            m_tcount--;
         end
         m_on_timer[t] = 1'b0;
      end
      m_state[t] = psched_pkg::ST_READY;
      queue_append(t);
   endfunction

   // work out the result word of one operation and advance the model
   function automatic sched_result_type schedule_step(logic [2:0] fn, logic [4:0] t,
                                                      logic [4:0] prio, logic [31:0] dur);
      sched_result_type r;
      logic [32:0] sum;
      r = '0;
      if (fn == psched_pkg::FUNC_ACTIVATE) begin
         if (m_state[t] == psched_pkg::ST_STANDBY) begin
            m_level[t] = prio; m_state[t] = psched_pkg::ST_READY;
            queue_append(t);
            r.dispatch = 1'b1;
         end
      end else if (fn == psched_pkg::FUNC_SLEEP || fn == psched_pkg::FUNC_TSLEEP ||
                   fn == psched_pkg::FUNC_DORMANT) begin
         if (m_state[t] != psched_pkg::ST_READY) r.status = 1'b1;
         else begin
            queue_unlink(t);
            if (fn == psched_pkg::FUNC_DORMANT) m_state[t] = psched_pkg::ST_DORMANT;
            else begin
               m_state[t] = psched_pkg::ST_WAIT;
               if (fn == psched_pkg::FUNC_TSLEEP) begin
                  sum = {1'b0, m_ticks} + {1'b0, dur};
                  m_wake[t] = sum[32] ? 32'hffff_ffff : sum[31:0];
                  timeout_insert(t);
               end
            end
            r.dispatch = 1'b1;
         end
      end else if (fn == psched_pkg::FUNC_WAKEUP) begin
         if (m_state[t] != psched_pkg::ST_WAIT) r.status = 1'b1;
         else begin
            release_task(t);
            r.dispatch = 1'b1;
         end
      end else if (fn == psched_pkg::FUNC_TICK) begin
         if (m_ticks != 32'hffff_ffff) m_ticks++;
         while (m_tcount != 0 && m_ticks >= m_wake[m_thead]) begin
            release_task(m_thead);
            r.woken_count++;
         end
         if (r.woken_count != 0) r.dispatch = 1'b1;
      end
      for (int lv = psched_pkg::LEVELS - 1; lv >= 0; lv--)
         if (m_ready_bits[lv]) begin
            r.next_task = m_head[lv];
            r.next_valid = 1'b1;
         end
      return r;
   endfunction

   // send one word, predict its result on acceptance; valid stays up for the next word
   task automatic send_op(logic [2:0] fn, logic [4:0] t, logic [4:0] prio,
                          logic [31:0] dur);
      int gap;
      if (!calm && $urandom_range(0, 5) == 0) begin
         gap = $urandom_range(1, 16);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_func <= fn; req_task_id <= t; req_priority_req <= prio; req_duration <= dur;
      do @(posedge clock); while (!req_ready);
      expected_words.push_back(schedule_step(fn, t, prio, dur));
   endtask

   // stop offering and wait for every outstanding result word
   task automatic drain_results();
      req_valid <= 1'b0;
      while (expected_words.size() != 0) @(posedge clock);
   endtask

   function automatic logic [31:0] rand_duration();
      case ($urandom_range(0, 5))
         0: return '0;
         1: return 32'hffff_ffff;
         2: return $urandom;
         default: return $urandom_range(0, 12);
      endcase
   endfunction

   // directed: field extremes, every operation, rejections, an all-ones wake time
   task automatic test_directed();
      send_op(psched_pkg::FUNC_SLEEP, 5'd0, 5'd0, '0);        // sleep on standby: rejected
      send_op(psched_pkg::FUNC_WAKEUP, 5'd31, 5'd0, '0);      // wakeup on non-waiting
      send_op(psched_pkg::FUNC_DORMANT, 5'd3, 5'd0, '0);
      send_op(psched_pkg::FUNC_ACTIVATE, 5'd31, 5'd31, '0);
      send_op(psched_pkg::FUNC_ACTIVATE, 5'd0, 5'd0, '0);
      send_op(psched_pkg::FUNC_ACTIVATE, 5'd1, 5'd0, '0);
      send_op(psched_pkg::FUNC_ACTIVATE, 5'd1, 5'd4, '0);     // already ready: no change
      send_op(psched_pkg::FUNC_TSLEEP, 5'd0, 5'd0, 32'd2);
      send_op(psched_pkg::FUNC_TSLEEP, 5'd1, 5'd0, 32'd2);    // equal time goes in front
      send_op(psched_pkg::FUNC_TSLEEP, 5'd31, 5'd0, 32'hffff_ffff);
      send_op(psched_pkg::FUNC_TICK, 5'd0, 5'd0, '0);
      send_op(psched_pkg::FUNC_TICK, 5'd9, 5'd9, '1);         // wakes two at once
      send_op(psched_pkg::FUNC_WAKEUP, 5'd31, 5'd0, '0);      // removed from timeout list
      send_op(psched_pkg::FUNC_SLEEP, 5'd1, 5'd0, '0);
      send_op(psched_pkg::FUNC_WAKEUP, 5'd1, 5'd0, '0);
      send_op(psched_pkg::FUNC_DORMANT, 5'd0, 5'd0, '0);
      send_op(psched_pkg::FUNC_ACTIVATE, 5'd0, 5'd2, '0);     // dormant stays dormant
      send_op(psched_pkg::FUNC_TSLEEP, 5'd1, 5'd0, 32'd0);
      send_op(psched_pkg::FUNC_TICK, 5'd0, 5'd0, '0);
      send_op(3'd6, 5'd7, 5'd7, '0);                          // unknown codes ignored
      send_op(3'd7, 5'd31, 5'd31, '1);
      drain_results();
   endtask

   // random operations weighted towards well-formed sequences
   task automatic test_random(int count);
      logic [4:0] t;
      logic [2:0] fn;
      for (int n = 0; n < count; n++) begin
         t = 5'($urandom_range(0, psched_pkg::TASKS - 1));
         case ($urandom_range(0, 19))
            0, 1, 2, 3: fn = psched_pkg::FUNC_ACTIVATE;
            4, 5: fn = psched_pkg::FUNC_SLEEP;
            6, 7, 8, 9: fn = psched_pkg::FUNC_TSLEEP;
            10, 11: fn = psched_pkg::FUNC_WAKEUP;
            12: fn = psched_pkg::FUNC_DORMANT;
            19: fn = 3'($urandom_range(6, 7));
            default: fn = psched_pkg::FUNC_TICK;
         endcase
         // steer towards tasks in the right state most of the time
         if ($urandom_range(0, 3) != 0)
            for (int k = 0; k < psched_pkg::TASKS; k++) begin
               if ((fn == psched_pkg::FUNC_ACTIVATE && m_state[t] == psched_pkg::ST_STANDBY) ||
                   (fn == psched_pkg::FUNC_WAKEUP && m_state[t] == psched_pkg::ST_WAIT) ||
                   ((fn == psched_pkg::FUNC_SLEEP || fn == psched_pkg::FUNC_TSLEEP ||
                     fn == psched_pkg::FUNC_DORMANT) &&
                    m_state[t] == psched_pkg::ST_READY))
                  break;
               t = t + 5'd1;
            end
         send_op(fn, t, 5'($urandom), rand_duration());
      end
   endtask

   // receiver holds off for a long stretch while the sender keeps offering words
   task automatic test_backpressure();
      long_hold = 300;
      rx_hold = 1'b1;
      test_random(20);
      rx_hold = 1'b0;
      drain_results();
   endtask

   // check each result word against the oldest prediction
   always @(posedge clock) begin
      sched_result_type exp_w;
      cycle <= cycle + 1;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_words.size() == 0) begin
            $error("result word with nothing expected");
            errors++;
         end else begin
            exp_w = expected_words.pop_front();
            if (rsp_status !== exp_w.status) begin
               $error("status exp %0d got %0d", exp_w.status, rsp_status); errors++;
            end
            if (rsp_next_task !== exp_w.next_task) begin
               $error("next_task exp %0d got %0d", exp_w.next_task, rsp_next_task);
               errors++;
            end
            if (rsp_next_valid !== exp_w.next_valid) begin
               $error("next_valid exp %0d got %0d", exp_w.next_valid, rsp_next_valid);
               errors++;
            end
            if (rsp_dispatch !== exp_w.dispatch) begin
               $error("dispatch exp %0d got %0d", exp_w.dispatch, rsp_dispatch); errors++;
            end
            if (rsp_woken_count !== exp_w.woken_count) begin
               $error("woken_count exp %0d got %0d", exp_w.woken_count, rsp_woken_count);
               errors++;
            end
         end
      end
      if (cycle > 2000000) begin
         $display("priority_task_scheduler_with_timeouts regression: fail");
         $finish;
      end
   end

   // receiver ready: random stall bursts, plus the long hold-off
   initial begin
      int burst;
      @(negedge reset);
      forever begin
         if (rx_hold && long_hold > 0) begin
            rsp_ready <= 1'b0;
            repeat (long_hold) @(posedge clock);
            long_hold = 0;
         end else if (!calm && $urandom_range(0, 4) == 0) begin
            burst = $urandom_range(1, 16);
            rsp_ready <= 1'b0;
            repeat (burst) @(posedge clock);
         end else begin
            burst = $urandom_range(1, 16);
            rsp_ready <= 1'b1;
            repeat (burst) @(posedge clock);
         end
      end
   end

   initial begin
      model_reset();
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_backpressure();
      test_random(700);
      drain_results();   // sender pauses until everything has come back
      test_random(400);
      calm = 1'b1;
      test_random(300);
      drain_results();
      repeat (50) @(posedge clock);
      if (errors == 0)
         $display("priority_task_scheduler_with_timeouts regression: pass");
      else
         $display("priority_task_scheduler_with_timeouts regression: fail");
      $finish;
   end

endmodule

### priority_task_scheduler_with_timeouts.f
rtl/psched_pkg.sv
rtl/psched_alu.sv
rtl/psched_ffs.sv
rtl/priority_task_scheduler_with_timeouts.sv
bench/tb_priority_task_scheduler_with_timeouts.sv
